// ===== rtl/core/integer_to_ascii_formatter_assert.svh =====
// Assertion macros for the formatter RTL.
// Define NO_ASSERTIONS to compile them away.
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Property checked on every rising clock edge outside reset.
`define I2A_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("formatter assertion failed");
// Condition that must never be seen outside reset.
`define I2A_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("formatter forbidden condition seen");
`else
`define I2A_ASSERT(label, clk, rst_n, prop)
`define I2A_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== rtl/core/i2a_pkg.sv =====
// ----------------------------------------------------------------------------
// i2a_pkg
// Constants, item type and helpers shared by the integer-to-ASCII formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

  localparam int VALUE_WIDTH     = 64;
  localparam int STEPS_PER_STAGE = 8;
  localparam int NUM_STAGES      = (VALUE_WIDTH + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int BIN_W           = NUM_STAGES * STEPS_PER_STAGE;
  localparam int DEC_DIGITS      = 20;
  localparam int DEC_W           = DEC_DIGITS * 4;
  localparam int HEX_DIGITS      = (VALUE_WIDTH + 3) / 4;
  localparam int MAX_CHARS       = 20;
  localparam int LEN_W           = 5;
  localparam int IDX_W           = 5;

  // Format commands
  localparam logic [1:0] CMD_SDEC = 2'd0;
  localparam logic [1:0] CMD_UDEC = 2'd1;
  localparam logic [1:0] CMD_HEX  = 2'd2;
  localparam logic [1:0] CMD_RSVD = 2'd3;  // decoded as hex

  // ASCII codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_X     = 8'h78;

  // One request moving through the conversion pipeline
  typedef struct packed {
    logic             hex;
    logic             neg;
    logic [BIN_W-1:0] bin;
    logic [DEC_W-1:0] bcd;
  } item_t;

  function automatic logic [7:0] hex_glyph(input logic [3:0] nib);
    if (nib < 4'd10) return CH_ZERO + {4'd0, nib};
    return CH_UPA + {4'd0, nib} - 8'd10;
  endfunction

endpackage

// ===== rtl/core/i2a_dabble_stage.sv =====
// ----------------------------------------------------------------------------
// i2a_dabble_stage
// One pipeline stage of the binary-to-BCD converter: eight shift-add-3 steps.
// ----------------------------------------------------------------------------
module i2a_dabble_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  i2a_pkg::item_t item_i,
  output logic           ready_o,
  output logic           valid_o,
  output i2a_pkg::item_t item_o,
  input  logic           ready_i
);

  logic           vld_q;
  i2a_pkg::item_t item_q, item_d;

  // Eight double-dabble steps; hex requests pass untouched
  always_comb begin
    logic [i2a_pkg::DEC_W-1:0] b;
    logic [i2a_pkg::BIN_W-1:0] m;
    b = item_i.bcd;
    m = item_i.bin;
    if (!item_i.hex) begin
      for (int s = 0; s < i2a_pkg::STEPS_PER_STAGE; s++) begin
        for (int d = 0; d < i2a_pkg::DEC_DIGITS; d++) begin
          if (b[d*4 +: 4] >= 4'd5) b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
        end
        b = {b[i2a_pkg::DEC_W-2:0], m[i2a_pkg::BIN_W-1]};
        m = {m[i2a_pkg::BIN_W-2:0], 1'b0};
      end
    end
    item_d     = item_i;
    item_d.bcd = b;
    item_d.bin = m;
  end

  assign ready_o = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== rtl/core/i2a_emit.sv =====
// ----------------------------------------------------------------------------
// i2a_emit
// Builds the character buffer of a converted number and sends it out,
// most significant character first, one request per character.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_formatter_assert.svh"

module i2a_emit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  i2a_pkg::item_t item_i,
  output logic           ready_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     ascii_char_o,
  output logic           last_o,
  output logic [4:0]     total_length_o
);

  logic                          vld_q;
  logic [i2a_pkg::IDX_W-1:0]     idx_q;
  logic [i2a_pkg::LEN_W-1:0]     len_q, len_d;
  logic [7:0]                    buf_q [i2a_pkg::MAX_CHARS];
  logic [7:0]                    buf_d [i2a_pkg::MAX_CHARS];
  logic                          done;

  // Digit count, length and characters, least significant first
  always_comb begin
    logic [i2a_pkg::LEN_W-1:0] nd;
    nd = 5'd1;
    if (item_i.hex) begin
      for (int i = 1; i < i2a_pkg::HEX_DIGITS; i++) begin
        if (item_i.bin[i*4 +: 4] != 4'd0) nd = i2a_pkg::LEN_W'(i + 1);
      end
    end else begin
      for (int i = 1; i < i2a_pkg::DEC_DIGITS; i++) begin
        if (item_i.bcd[i*4 +: 4] != 4'd0) nd = i2a_pkg::LEN_W'(i + 1);
      end
    end
    if (item_i.hex)      len_d = nd + 5'd2;
    else if (item_i.neg) len_d = nd + 5'd1;
    else                 len_d = nd;
    for (int i = 0; i < i2a_pkg::MAX_CHARS; i++) begin
      if (i2a_pkg::LEN_W'(i) < nd) begin
        if (item_i.hex && i < i2a_pkg::HEX_DIGITS)
          buf_d[i] = i2a_pkg::hex_glyph(item_i.bin[(i % i2a_pkg::HEX_DIGITS)*4 +: 4]);
        else
          buf_d[i] = i2a_pkg::CH_ZERO + {4'd0, item_i.bcd[i*4 +: 4]};
      end else if (i2a_pkg::LEN_W'(i) == nd) begin
        buf_d[i] = item_i.hex ? i2a_pkg::CH_X : i2a_pkg::CH_MINUS;
      end else begin
        buf_d[i] = i2a_pkg::CH_ZERO;
      end
    end
  end

  assign done    = vld_q && !out_stall_i && (idx_q == '0);
  assign ready_o = !vld_q || done;

  assign out_valid_o    = vld_q;
  assign ascii_char_o   = buf_q[idx_q];
  assign last_o         = (idx_q == '0);
  assign total_length_o = len_q;

  // Character counter and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
      len_q <= '0;
    end else if (ready_o) begin
      vld_q <= valid_i;
      if (valid_i) begin
        idx_q <= len_d - 5'd1;
        len_q <= len_d;
      end
    end else if (!out_stall_i) begin
      idx_q <= idx_q - 1'b1;
    end
  end

  // Character buffer
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      buf_q <= buf_d;
    end
  end

  `I2A_ASSERT(a_hold_on_stall, clk_i, rst_ni, vld_q && out_stall_i |=> vld_q && $stable(idx_q))
  `I2A_ASSERT(a_idx_in_len, clk_i, rst_ni, vld_q |-> idx_q < len_q)
  `I2A_ASSERT(a_len_range, clk_i, rst_ni, vld_q |-> len_q >= 5'd1 && len_q <= 5'd20)
  `I2A_NEVER(a_no_phantom, clk_i, rst_ni, $past(done) && !$past(valid_i) && vld_q)

endmodule

// ===== rtl/core/integer_to_ascii_formatter.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats a 64-bit value as signed decimal, unsigned decimal or 0x-hex text.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: cmd_i/value_i with in_valid_i; accepted when in_valid_i is
//   high and in_stall_o is low. cmd 0 signed decimal, 1 unsigned decimal,
//   2 (and 3) upper-case hex with a "0x" prefix.
//   Output channel: one request per ASCII character, most significant first,
//   on ascii_char_o with out_valid_o; taken when out_stall_i is low. Every
//   character carries total_length_o; the final one raises last_o.
//   Pipeline: ten register stages: one operand stage (loaded at the accepting
//   edge), eight converter stages of eight shift-add-3 steps each, and the
//   character buffer stage, which presents the characters.
//   Throughput: an item can enter every cycle while the pipeline has room;
//   the buffer stage holds a number (total_length 1 to 20 characters) until
//   its last character is taken, and can load the next number as it is taken.
//   A stalled receiver holds the current character and backs up the
//   pipeline stage by stage; nothing is lost or repeated.
//   Reset clears all valid bits and the emit index and length; data is not reset.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [63:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  ascii_char_o,
  output logic        last_o,
  output logic [4:0]  total_length_o
);

  localparam int NS = i2a_pkg::NUM_STAGES;

  logic                              vld_w [NS+1];
  logic                              rdy_w [NS+1];
  i2a_pkg::item_t                    item_w [NS+1];
  logic [i2a_pkg::VALUE_WIDTH-1:0]   v, mag;
  logic                              neg;
  logic                              emit_rdy;
  i2a_pkg::item_t                    prep_d, prep_q;
  logic                              prep_vld_q;

  // Operand stage: sign and magnitude
  always_comb begin
    v          = value_i[i2a_pkg::VALUE_WIDTH-1:0];
    neg        = (cmd_i == i2a_pkg::CMD_SDEC) && v[i2a_pkg::VALUE_WIDTH-1];
    mag        = neg ? (~v + 1'b1) : v;
    prep_d.hex = (cmd_i == i2a_pkg::CMD_HEX) || (cmd_i == i2a_pkg::CMD_RSVD);
    prep_d.neg = neg;
    prep_d.bin = i2a_pkg::BIN_W'(mag);
    prep_d.bcd = '0;
  end

  assign rdy_w[0]   = !prep_vld_q || rdy_w[1];
  assign in_stall_o = !rdy_w[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_vld_q <= 1'b0;
    end else if (rdy_w[0]) begin
      prep_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_w[0] && in_valid_i) begin
      prep_q <= prep_d;
    end
  end

  assign vld_w[0]  = prep_vld_q;
  assign item_w[0] = prep_q;

  // Binary-to-BCD converter stages
  for (genvar g = 0; g < NS; g++) begin : g_dabble
    i2a_dabble_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld_w[g]),
      .item_i  (item_w[g]),
      .ready_o (rdy_w[g+1]),
      .valid_o (vld_w[g+1]),
      .item_o  (item_w[g+1]),
      .ready_i ((g == NS-1) ? emit_rdy : rdy_w[g+2 > NS ? NS : g+2])
    );
  end

  // Character buffer and output
  i2a_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (vld_w[NS]),
    .item_i         (item_w[NS]),
    .ready_o        (emit_rdy),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .ascii_char_o   (ascii_char_o),
    .last_o         (last_o),
    .total_length_o (total_length_o)
  );

endmodule
